// ===== design/swms_pkg.sv =====
// swms_pkg: shared widths and types for the sliding-window mean/stdev block.
// No dependencies; imported by every module of the block.
`default_nettype none
package swms_pkg;
	localparam int WINDOW_MAX  = 128;
	localparam int IDX_W       = $clog2(WINDOW_MAX);
	localparam int CNT_W       = 8;
	localparam int SAMPLE_BITS = 24;
	localparam int SUM_W       = 31;
	localparam int SQ_W        = 54;
	localparam int SPAN_W      = 25;
	localparam int NUM_W       = 62;
	localparam int DIV_W       = 78;
	localparam int DVS_W       = 15;
	localparam int DIV_ITER    = DIV_W / 2;
	localparam int DIV_CW      = $clog2(DIV_ITER);
	localparam int RAD_W       = 64;
	localparam int ROOT_W      = 32;
	localparam int REM_W       = 35;
	localparam int ROOT_CW     = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] LEN_RESET = 8'd30;

	typedef struct packed {
		logic                     done;
		logic signed [SUM_W-1:0]  sum;
		logic [SQ_W-1:0]          sumsq;
		logic [CNT_W-1:0]         count;
		logic signed [SPAN_W-1:0] span;
	} swms_stats_t;
endpackage
`default_nettype wire

// ===== design/swms_ring.sv =====
// swms_ring: sample ring memory, indices and running sums.
// Read-modify-write sequence per word. Depends on swms_pkg.
`default_nettype none
module swms_ring (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [swms_pkg::CNT_W-1:0]           cfg_wdata,
	input  wire logic                                 start,
	input  wire logic signed [swms_pkg::SAMPLE_BITS-1:0] sample,
	output swms_pkg::swms_stats_t                     stats
);
	import swms_pkg::*;

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_RD1  = 2'd1;
	localparam logic [1:0] R_RD2  = 2'd2;
	localparam logic [1:0] R_UPD  = 2'd3;

	logic [1:0]                   state_q;
	logic [CNT_W-1:0]             len_q;
	logic [IDX_W-1:0]             wi_q, wi_s1, nxt_s1, oldest_s1;
	logic [CNT_W-1:0]             held_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]              sq_q;
	logic signed [SPAN_W-1:0]     span_q;
	logic                         done_q;
	logic signed [SAMPLE_BITS-1:0] x_s1, old_s2;
	logic                         full_s1;
	logic [2*SAMPLE_BITS-1:0]     xsq_s2, osq_s2;

	logic [SAMPLE_BITS-1:0]       mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0]       rdata;
	logic [IDX_W-1:0]             raddr;
	logic                         we;

	logic [CNT_W-1:0]             n;
	logic [IDX_W-1:0]             wi_eff, nxt;
	logic [CNT_W-1:0]             nxt_w;
	logic signed [SAMPLE_BITS-1:0] old_v, oldest;

	always_comb begin
		if (len_q == '0)
			n = CNT_W'(1);
		else if (len_q > CNT_W'(WINDOW_MAX))
			n = CNT_W'(WINDOW_MAX);
		else
			n = len_q;
		wi_eff = ({1'b0, wi_q} >= n) ? '0 : wi_q;
		nxt_w  = {1'b0, wi_eff} + CNT_W'(1);
		nxt    = (nxt_w == n) ? '0 : nxt_w[IDX_W-1:0];
		old_v  = full_s1 ? $signed(rdata) : '0;
		// oldest entry may be the slot being written this word
		oldest = (oldest_s1 == wi_s1) ? x_s1 : $signed(rdata);
		raddr  = (state_q == R_RD1) ? wi_s1 : oldest_s1;
		we     = (state_q == R_UPD);
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wi_s1] <= x_s1;
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == R_IDLE && start) begin
			x_s1      <= sample;
			wi_s1     <= wi_eff;
			nxt_s1    <= nxt;
			full_s1   <= (held_q >= n);
			oldest_s1 <= (held_q >= n) ? nxt : '0;
		end
		if (state_q == R_RD2) begin
			old_s2 <= old_v;
			xsq_s2 <= x_s1 * x_s1;
			osq_s2 <= old_v * old_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			len_q   <= LEN_RESET;
			wi_q    <= '0;
			held_q  <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			span_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				len_q  <= cfg_wdata;
				wi_q   <= '0;
				held_q <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end
			case (state_q)
				R_IDLE: begin
					if (start)
						state_q <= R_RD1;
				end
				R_RD1: state_q <= R_RD2;
				R_RD2: state_q <= R_UPD;
				R_UPD: begin
					wi_q    <= nxt_s1;
					held_q  <= full_s1 ? n : held_q + CNT_W'(1);
					sum_q   <= sum_q + SUM_W'(x_s1) - SUM_W'(old_s2);
					sq_q    <= sq_q + SQ_W'(xsq_s2) - SQ_W'(osq_s2);
					span_q  <= SPAN_W'(x_s1) - SPAN_W'(oldest);
					done_q  <= 1'b1;
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign stats.done  = done_q;
	assign stats.sum   = sum_q;
	assign stats.sumsq = sq_q;
	assign stats.count = held_q;
	assign stats.span  = span_q;
endmodule
`default_nettype wire

// ===== design/swms_div.sv =====
// swms_div: unsigned restoring divider, two quotient bits per cycle.
// Depends on swms_pkg.
`default_nettype none
module swms_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [swms_pkg::DIV_W-1:0] dividend,
	input  wire logic [swms_pkg::DVS_W-1:0] divisor,
	output logic                            done,
	output logic [swms_pkg::DIV_W-1:0]      quotient
);
	import swms_pkg::*;

	logic [DIV_W-1:0]  qd_q, qd_n;
	logic [DVS_W-1:0]  r_q, r_n, d_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [DVS_W:0]    sh;
	logic              b;

	always_comb begin
		r_n  = r_q;
		qd_n = qd_q;
		sh   = '0;
		b    = 1'b0;
		for (int i = 0; i < 2; i++) begin
			sh = {r_n, qd_n[DIV_W-1]};
			if (sh >= {1'b0, d_q}) begin
				sh = sh - {1'b0, d_q};
				b  = 1'b1;
			end else begin
				b  = 1'b0;
			end
			r_n  = sh[DVS_W-1:0];
			qd_n = {qd_n[DIV_W-2:0], b};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q <= dividend;
			r_q  <= '0;
			d_q  <= divisor;
		end else if (busy_q) begin
			qd_q <= qd_n;
			r_q  <= r_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(DIV_ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;
endmodule
`default_nettype wire

// ===== design/swms_sqrt.sv =====
// swms_sqrt: bit-serial integer square root, one result bit per cycle.
// Depends on swms_pkg.
`default_nettype none
module swms_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [swms_pkg::RAD_W-1:0]  radicand,
	output logic                             done,
	output logic [swms_pkg::ROOT_W-1:0]      root
);
	import swms_pkg::*;

	logic [RAD_W-1:0]   v_q;
	logic [REM_W-1:0]   rem_q, remsh, trial;
	logic [ROOT_W-1:0]  root_q;
	logic [ROOT_CW-1:0] cnt_q;
	logic               busy_q, done_q;

	always_comb begin
		remsh = {rem_q[REM_W-3:0], v_q[RAD_W-1:RAD_W-2]};
		trial = REM_W'({root_q, 2'b01});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[RAD_W-3:0], 2'b00};
			if (remsh >= trial) begin
				rem_q  <= remsh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= remsh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + ROOT_CW'(1);
				if (cnt_q == ROOT_CW'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== design/sliding_window_mean_stdev.sv =====
// Top level: ring update, multiply, two dividers, square root, output register.
// Depends on swms_pkg, swms_ring, swms_div, swms_sqrt.
//
//   port group   dir  handshake            payload
//   config       in   cfg_we               cfg_wdata (window_len)
//   input        in   in_valid/in_ready    sample
//   output       out  out_valid/out_ready  mean_q8, stdev_q8, span, fill_count
//
// One word at a time, from accept to result: the ring read/read/write and its done
// flag, products and difference, a step to start the radix-4 dividers and the
// dividers themselves (39 steps, mean and variance side by side), a step to start
// the root unit and the root unit itself (32 steps), then the load.
// in_ready is high only while idle, so no word is accepted until the one before
// it is loaded; a finished result waits in the output register, and the next
// word may be accepted while it waits. A second result holds in the load step
// until out_ready. Reset window length is 30; the sample memory has no reset.
`default_nettype none
module sliding_window_mean_stdev (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [swms_pkg::CNT_W-1:0]              cfg_wdata,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic signed [swms_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed [31:0]                           mean_q8,
	output logic [30:0]                                  stdev_q8,
	output logic signed [swms_pkg::SPAN_W-1:0]           span,
	output logic [swms_pkg::CNT_W-1:0]                   fill_count
);
	import swms_pkg::*;

	localparam logic [3:0] T_IDLE = 4'd0;
	localparam logic [3:0] T_RING = 4'd1;
	localparam logic [3:0] T_MUL  = 4'd2;
	localparam logic [3:0] T_SUB  = 4'd3;
	localparam logic [3:0] T_DGO  = 4'd4;
	localparam logic [3:0] T_DIV  = 4'd5;
	localparam logic [3:0] T_RGO  = 4'd6;
	localparam logic [3:0] T_ROOT = 4'd7;
	localparam logic [3:0] T_OUT  = 4'd8;

	logic [3:0]               state_q;
	swms_stats_t              st;
	logic                     accept;
	logic [SUM_W-1:0]         s1mag;
	logic [NUM_W-1:0]         cs2_s1, s1sq_s1, num_s2;
	logic [DVS_W-1:0]         c2_s1;
	logic                     vdone, mdone, rdone;
	logic [DIV_W-1:0]         vq, mq;
	logic [ROOT_W-1:0]        rt;
	logic                     load;
	logic [DIV_W-1:0]         mean_w;
	logic                     out_valid_q;
	logic signed [31:0]       mean_q;
	logic [30:0]              stdev_q;
	logic signed [SPAN_W-1:0] span_q;
	logic [CNT_W-1:0]         fill_q;

	assign in_ready = (state_q == T_IDLE);
	assign accept   = in_valid && in_ready;
	assign s1mag    = st.sum[SUM_W-1] ? SUM_W'(-st.sum) : SUM_W'(st.sum);
	assign load     = (state_q == T_OUT) && (!out_valid_q || out_ready);
	assign mean_w   = st.sum[SUM_W-1] ? -mq : mq;

	swms_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (accept),
		.sample    (sample),
		.stats     (st)
	);

	swms_div u_div_var (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == T_DGO),
		.dividend ({num_s2, 16'b0}),
		.divisor  (c2_s1),
		.done     (vdone),
		.quotient (vq)
	);

	swms_div u_div_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == T_DGO),
		.dividend (DIV_W'({s1mag, 8'b0})),
		.divisor  (DVS_W'(st.count)),
		.done     (mdone),
		.quotient (mq)
	);

	swms_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == T_RGO),
		.radicand (vq[RAD_W-1:0]),
		.done     (rdone),
		.root     (rt)
	);

	always_ff @(posedge clk) begin
		if (state_q == T_MUL) begin
			cs2_s1  <= NUM_W'(st.count) * NUM_W'(st.sumsq);
			s1sq_s1 <= NUM_W'(s1mag) * NUM_W'(s1mag);
			c2_s1   <= DVS_W'(st.count) * DVS_W'(st.count);
		end
		if (state_q == T_SUB)
			num_s2 <= (cs2_s1 > s1sq_s1) ? cs2_s1 - s1sq_s1 : '0;
		if (load) begin
			mean_q  <= mean_w[31:0];
			stdev_q <= rt[ROOT_W-1] ? 31'h7FFF_FFFF : rt[30:0];
			span_q  <= st.span;
			fill_q  <= st.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (accept)
						state_q <= T_RING;
				end
				T_RING: begin
					if (st.done)
						state_q <= T_MUL;
				end
				T_MUL: state_q <= T_SUB;
				T_SUB: state_q <= T_DGO;
				T_DGO: state_q <= T_DIV;
				T_DIV: begin
					if (vdone && mdone)
						state_q <= T_RGO;
				end
				T_RGO: state_q <= T_ROOT;
				T_ROOT: begin
					if (rdone)
						state_q <= T_OUT;
				end
				T_OUT: begin
					if (load)
						state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_q8    = mean_q;
	assign stdev_q8   = stdev_q;
	assign span       = span_q;
	assign fill_count = fill_q;

	// both dividers run the same length and must finish together
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vdone == mdone) else $error("divider done mismatch");

	a_ring_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |-> state_q == T_RING) else $error("ring done outside ring phase");

	a_root_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rdone |-> state_q == T_ROOT) else $error("root done outside root phase");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_count != '0) else $error("result word with empty window");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for sliding_window_mean_stdev (ring mean/stdev/span/fill).
// Depends on swms_pkg and the sliding_window_mean_stdev RTL; stands alone otherwise.
`timescale 1ns / 100ps
module tb;
	import swms_pkg::*;

	typedef struct {
		logic signed [31:0] mean;
		logic [30:0]        sd;
		logic signed [24:0] sp;
		logic [7:0]         cnt;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] mean_q8;
	logic [30:0] stdev_q8;
	logic signed [SPAN_W-1:0] span;
	logic [CNT_W-1:0] fill_count;

	sliding_window_mean_stdev dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .mean_q8(mean_q8),
		.stdev_q8(stdev_q8), .span(span), .fill_count(fill_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	int                win_len;
	logic signed [23:0] ring [WINDOW_MAX];
	int                wr_pos;
	int                held;
	longint            sum_x;
	logic [63:0]       sum_x2;

	stats_t expected_stats[$];
	int     mismatches = 0;
	bit     calm = 1'b0;

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic stats_t window_stats(logic signed [23:0] x);
		stats_t s;
		int n;
		longint old, oldest, xx, m;
		logic [63:0] c, c2, num, sq, q, r, v, rt, am;
		n = win_len < 1 ? 1 : (win_len > WINDOW_MAX ? WINDOW_MAX : win_len);
		xx = x;
		old = 0;
		if (wr_pos >= n) wr_pos = 0;
		if (held >= n) begin
			held = n;
			old = ring[wr_pos];
			ring[wr_pos] = x;
			wr_pos = (wr_pos + 1) % n;
			oldest = ring[wr_pos];
		end else begin
			ring[wr_pos] = x;
			held++;
			oldest = ring[0];
			wr_pos = (wr_pos + 1) % n;
		end
		sum_x += xx - old;
		sum_x2 = sum_x2 + 64'(xx * xx) - 64'(old * old);
		c = held;
		m = (sum_x * 256) / longint'(held);
		c2 = c * c;
		num = c * sum_x2;
		am = sum_x < 0 ? -sum_x : sum_x;
		sq = am * am;
		num = num > sq ? num - sq : 0;
		q = num / c2;
		r = num % c2;
		v = q * 65536 + (r * 65536) / c2;
		rt = root64(v);
		if (rt > 64'h7FFF_FFFF) rt = 64'h7FFF_FFFF;
		s.mean = m[31:0];
		s.sd = rt[30:0];
		s.sp = 25'(xx - oldest);
		s.cnt = c[7:0];
		return s;
	endfunction

	function automatic bit idle_now();
		return !calm && $urandom_range(99) < 37;
	endfunction

	// result checker
	always @(posedge clk) begin
		stats_t e;
		if (arst_n) begin
			out_ready <= !idle_now();
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result word mean=%0d", mean_q8);
				end else begin
					e = expected_stats.pop_front();
					if (e.mean !== mean_q8 || e.sd !== stdev_q8 || e.sp !== span ||
					    e.cnt !== fill_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp mean=%0d sd=%0d span=%0d cnt=%0d got %0d %0d %0d %0d",
								e.mean, e.sd, e.sp, e.cnt, mean_q8, stdev_q8, span, fill_count);
					end
				end
			end
		end
	end

	// valid stays up after an accept until the next word, an idle cycle or a drain
	task automatic send_word(logic signed [23:0] x);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= x;
		do @(posedge clk); while (!in_ready);
		expected_stats.insert(expected_stats.size(), window_stats(x));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_window(int len);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= len[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len = len;
		wr_pos = 0;
		held = 0;
		sum_x = 0;
		sum_x2 = 0;
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(4))
			0: return 24'sh7FFFFF - 24'($urandom_range(3));
			1: return 24'sh800000 + 24'($urandom_range(3));
			2: return 24'($signed(16'($urandom)));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic test_reset_window();
		// default length 30: fill past wrap with extremes
		send_word(24'sh7FFFFF);
		send_word(24'sh800000);
		send_word(24'sd0);
		send_word(-24'sd1);
		for (int i = 0; i < 30; i++) send_word(i[0] ? 24'sh7FFFFF : 24'sh800000);
	endtask

	task automatic test_len_edges();
		set_window(0);
		send_word(24'sd5); send_word(-24'sd7); send_word(24'sh800000);
		set_window(1);
		send_word(24'sh7FFFFF); send_word(24'sh800000);
		set_window(255);
		for (int i = 0; i < 130; i++) send_word(24'sh7FFFFF);
		set_window(128);
		for (int i = 0; i < 130; i++) send_word(24'sh800000);
	endtask

	task automatic test_random();
		int lens[6] = '{2, 3, 7, 30, 100, 128};
		for (int p = 0; p < 8; p++) begin
			set_window(p < 6 ? lens[p] : $urandom_range(255));
			calm = (p == 3);
			for (int i = 0; i < 60; i++) send_word(rand_sample());
		end
		calm = 1'b0;
	endtask

	initial begin
		win_len = 30;
		wr_pos = 0;
		held = 0;
		sum_x = 0;
		sum_x2 = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_len_edges();
		test_random();
		drain();
		if (mismatches == 0 && expected_stats.size() == 0)
			$display("sliding_window_mean_stdev regression: pass");
		else
			$display("sliding_window_mean_stdev regression: fail");
		$finish;
	end

	initial begin
		#(12 * 1000000);
		$display("sliding_window_mean_stdev regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
design/swms_pkg.sv
design/swms_ring.sv
design/swms_div.sv
design/swms_sqrt.sv
design/sliding_window_mean_stdev.sv
tb/sv/tb.sv
